### sv/multiband_biquad_equalizer_assert.svh
// Assertion macros used by the checker file of the equalizer.
`ifndef MULTIBAND_BIQUAD_EQUALIZER_ASSERT_SVH
`define MULTIBAND_BIQUAD_EQUALIZER_ASSERT_SVH

// Checked at every rising edge of clk, suspended while reset is asserted.
`define MBEQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("equalizer check failed");

// Checked at every rising edge of clk, also during reset.
`define MBEQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("equalizer check failed");

`endif

### sv/mbeq_pkg.sv
package mbeq_pkg;

  localparam int NUM_COEFS = 5;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  localparam logic CFG_BAND_ENABLE = 1'b0;
  localparam logic CFG_PREAMP_GAIN = 1'b1;

  localparam int ENABLE_BITS = 10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAND,
    S_RUN,
    S_GAIN,
    S_OUT
  } state_t;

  // Operand that the shared multiplier takes in a given cycle.
  typedef enum logic [2:0] {
    OP_X,
    OP_X1,
    OP_X2,
    OP_Y1,
    OP_Y2,
    OP_GAIN
  } op_sel_t;

  typedef struct packed {
    logic       accept;
    logic       hist_rd;
    logic       coef_rd;
    logic [2:0] coef_idx;
    logic       mul_en;
    op_sel_t    op;
    logic       acc_init;
    logic       acc_add;
    logic       band_done;
    logic       out_load;
    logic [3:0] band;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic band_on;
    logic out_free;
  } dp_status_t;

endpackage

### sv/mbeq_ram.sv
module mbeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/mbeq_ctrl.sv
module mbeq_ctrl #(
  parameter int BANDS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbeq_pkg::dp_status_t status,
  output mbeq_pkg::dp_cmd_t    cmd
);
  import mbeq_pkg::*;

  localparam logic [2:0] STEP_READ     = 3'd0;
  localparam logic [2:0] STEP_LAST_RD  = 3'd4;
  localparam logic [2:0] STEP_MUL_LAST = 3'd5;
  localparam logic [2:0] STEP_ADD_FRST = 3'd2;
  localparam logic [2:0] STEP_ADD_LAST = 3'd6;
  localparam logic [2:0] STEP_WRITE    = 3'd7;
  localparam logic [3:0] LAST_BAND     = 4'(BANDS - 1);

  state_t     state_r, state_nxt;
  logic [3:0] band_r, band_nxt;
  logic [2:0] step_r, step_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      band_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      band_r  <= band_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    band_nxt  = band_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && status.is_sample) begin
          state_nxt = S_BAND;
          band_nxt  = '0;
        end
      end
      S_BAND: begin
        if (status.band_on) begin
          state_nxt = S_RUN;
          step_nxt  = STEP_READ;
        end else if (band_r == LAST_BAND) begin
          state_nxt = S_GAIN;
        end else begin
          band_nxt = band_r + 4'd1;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_WRITE) begin
          if (band_r == LAST_BAND) begin
            state_nxt = S_GAIN;
          end else begin
            state_nxt = S_BAND;
            band_nxt  = band_r + 4'd1;
          end
        end
      end
      S_GAIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_X;
    cmd.accept   = accept;
    cmd.band     = band_r;
    cmd.coef_idx = step_r;
    unique case (state_r)
      S_IDLE, S_BAND: begin
      end
      S_RUN: begin
        cmd.hist_rd   = (step_r == STEP_READ);
        cmd.acc_init  = (step_r == STEP_READ);
        cmd.coef_rd   = (step_r <= STEP_LAST_RD);
        cmd.mul_en    = (step_r != STEP_READ) && (step_r <= STEP_MUL_LAST);
        cmd.acc_add   = (step_r >= STEP_ADD_FRST) && (step_r <= STEP_ADD_LAST);
        cmd.band_done = (step_r == STEP_WRITE);
        // Coefficient k comes from a registered read, so its operand is selected in the step after the read.
        case (step_r)
          3'd1:    cmd.op = OP_X;
          3'd2:    cmd.op = OP_X1;
          3'd3:    cmd.op = OP_X2;
          3'd4:    cmd.op = OP_Y1;
          default: cmd.op = OP_Y2;
        endcase
      end
      S_GAIN: begin
        cmd.mul_en = 1'b1;
        cmd.op     = OP_GAIN;
      end
      S_OUT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/mbeq_dp.sv
module mbeq_dp #(
  parameter int BANDS             = 10,
  parameter int CHANNELS          = 2,
  parameter int HISTORY_FRAC_BITS = 24,
  parameter int COEF_FRAC_BITS    = 28
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbeq_pkg::dp_cmd_t    cmd,
  output mbeq_pkg::dp_status_t status,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_action,
  input  logic [2:0]           in_channel,
  input  logic signed [23:0]   in_sample_in,
  input  logic                 in_last_of_block,
  input  logic [3:0]           in_band,
  input  logic [2:0]           in_coef_index,
  input  logic signed [31:0]   in_coef_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_channel,
  output logic signed [23:0]   out_sample_out,
  output logic                 out_clipped,
  output logic                 out_last
);
  import mbeq_pkg::*;

  localparam int CDEPTH = BANDS * NUM_COEFS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int HDEPTH = BANDS * CHANNELS;
  localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int UP     = (HISTORY_FRAC_BITS >= 23) ? HISTORY_FRAC_BITS - 23 : 0;
  localparam int DN     = (HISTORY_FRAC_BITS < 23) ? 23 - HISTORY_FRAC_BITS : 0;
  localparam int OSH    = HISTORY_FRAC_BITS + 5;
  localparam logic signed [31:0] IN_RND  = 32'((64'd1 << DN) >> 1);
  localparam logic signed [66:0] ACC_RND = (67'd1 << COEF_FRAC_BITS) >> 1;
  localparam logic signed [65:0] OUT_RND = (66'd1 << OSH) >> 1;

  // Configuration registers.
  logic [ENABLE_BITS-1:0] band_enable_r;
  logic [31:0]            preamp_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_enable_r <= '0;
      preamp_gain_r <= 32'd268435456;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BAND_ENABLE: band_enable_r <= cfg_wdata[ENABLE_BITS-1:0];
        default:         preamp_gain_r <= cfg_wdata;
      endcase
    end
  end

  logic [15:0] en_vec;
  assign en_vec = 16'(band_enable_r);

  assign status.is_sample = (in_action == ACT_SAMPLE) && (4'(in_channel) < 4'(CHANNELS));
  assign status.band_on   = en_vec[cmd.band];
  assign status.out_free  = !out_valid || out_ready;

  // Coefficient store.
  logic              coef_we;
  logic [6:0]        coef_waddr_w, coef_raddr_w;
  logic [CDEPTH-1:0] coef_vld_r;
  logic              coef_vld_q_r;
  logic [31:0]       coef_rdata;

  assign coef_we = cmd.accept && (in_action == ACT_COEF) && (5'(in_band) < 5'(BANDS))
                   && (4'(in_coef_index) < 4'(NUM_COEFS));
  assign coef_waddr_w = 7'(in_band) * 7'(NUM_COEFS) + 7'(in_coef_index);
  assign coef_raddr_w = 7'(cmd.band) * 7'(NUM_COEFS) + 7'(cmd.coef_idx);

  mbeq_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr_w[CAW-1:0]),
    .wdata (in_coef_value),
    .re    (cmd.coef_rd),
    .raddr (coef_raddr_w[CAW-1:0]),
    .rdata (coef_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (coef_we) begin
      coef_vld_r[coef_waddr_w[CAW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_rd) begin
      coef_vld_q_r <= coef_vld_r[coef_raddr_w[CAW-1:0]];
    end
  end

  // Sample state.
  logic signed [31:0] x_r, x_nxt;
  logic [2:0]         ch_r;
  logic               last_r;
  logic signed [31:0] x_in;
  logic signed [31:0] y_sat;

  always_comb begin
    if (HISTORY_FRAC_BITS >= 23) begin
      x_in = 32'(in_sample_in) <<< UP;
    end else begin
      x_in = (32'(in_sample_in) + IN_RND) >>> DN;
    end
  end

  always_comb begin
    x_nxt = x_r;
    if (cmd.accept && status.is_sample) begin
      x_nxt = x_in;
    end else if (cmd.band_done) begin
      x_nxt = y_sat;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (cmd.accept && status.is_sample) begin
      ch_r   <= in_channel;
      last_r <= in_last_of_block;
    end
  end

  // Filter history: one row {y2, y1, x2, x1} per band and channel.
  logic [7:0]        hist_addr_w;
  logic [HDEPTH-1:0] hist_vld_r;
  logic              hist_vld_q_r;
  logic [127:0]      hist_rdata, hist_row, hist_wdata;

  assign hist_addr_w = 8'(cmd.band) * 8'(CHANNELS) + 8'(ch_r);
  assign hist_row    = hist_vld_q_r ? hist_rdata : '0;
  assign hist_wdata  = {hist_row[95:64], y_sat, hist_row[31:0], x_r};

  mbeq_ram #(.WIDTH(128), .DEPTH(HDEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.band_done),
    .waddr (hist_addr_w[HAW-1:0]),
    .wdata (hist_wdata),
    .re    (cmd.hist_rd),
    .raddr (hist_addr_w[HAW-1:0]),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (cmd.band_done) begin
      hist_vld_r[hist_addr_w[HAW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_rd) begin
      hist_vld_q_r <= hist_vld_r[hist_addr_w[HAW-1:0]];
    end
  end

  // Shared multiplier with registered product.
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod_w, prod_r;
  logic               prod_neg_r;

  always_comb begin
    mul_a = coef_vld_q_r ? 33'(signed'(coef_rdata)) : '0;
    case (cmd.op)
      OP_X:    mul_b = x_r;
      OP_X1:   mul_b = hist_row[31:0];
      OP_X2:   mul_b = hist_row[63:32];
      OP_Y1:   mul_b = hist_row[95:64];
      OP_Y2:   mul_b = hist_row[127:96];
      default: begin
        mul_a = {1'b0, preamp_gain_r};
        mul_b = x_r;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r     <= prod_w;
      prod_neg_r <= (cmd.op == OP_Y1) || (cmd.op == OP_Y2);
    end
  end

  // Accumulator, rounding and saturation of one band.
  logic signed [66:0] acc_r, prod_ext, acc_sh;

  assign prod_ext = 67'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc_r <= ACC_RND;
    end else if (cmd.acc_add) begin
      acc_r <= prod_neg_r ? acc_r - prod_ext : acc_r + prod_ext;
    end
  end

  assign acc_sh = acc_r >>> COEF_FRAC_BITS;

  always_comb begin
    if (acc_sh > 67'sd2147483647) begin
      y_sat = 32'sh7FFFFFFF;
    end else if (acc_sh < -67'sd2147483648) begin
      y_sat = 32'sh80000000;
    end else begin
      y_sat = acc_sh[31:0];
    end
  end

  // Output gain stage and result register.
  logic signed [65:0] out_sh;
  logic signed [23:0] out_sat;
  logic               out_clip;
  logic               out_valid_r;
  logic [2:0]         out_channel_r;
  logic signed [23:0] out_sample_r;
  logic               out_clipped_r, out_last_r;

  assign out_sh = (66'(prod_r) + OUT_RND) >>> OSH;

  always_comb begin
    out_clip = 1'b1;
    if (out_sh > 66'sd8388607) begin
      out_sat = 24'sh7FFFFF;
    end else if (out_sh < -66'sd8388608) begin
      out_sat = 24'sh800000;
    end else begin
      out_sat  = out_sh[23:0];
      out_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel_r <= ch_r;
      out_sample_r  <= out_sat;
      out_clipped_r <= out_clip;
      out_last_r    <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;
  assign out_last       = out_last_r;

endmodule

### sv/multiband_biquad_equalizer.sv
// A sample transaction walks the bands in order, and each enabled band runs five MACs
// through the one shared multiplier, fed by registered-read coefficient and history memories;
// a new transaction is taken only after the result is loaded into the output register.
// Coefficient write transactions are taken while idle and give no result. Synchronous active-low
// reset zeroes history and coefficients via valid bits, clears band_enable, sets unity gain.
module multiband_biquad_equalizer #(
  parameter int BANDS             = 10,
  parameter int CHANNELS          = 2,
  parameter int HISTORY_FRAC_BITS = 24,
  parameter int COEF_FRAC_BITS    = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [2:0]         in_channel,
  input  logic signed [23:0] in_sample_in,
  input  logic               in_last_of_block,
  input  logic [3:0]         in_band,
  input  logic [2:0]         in_coef_index,
  input  logic signed [31:0] in_coef_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_channel,
  output logic signed [23:0] out_sample_out,
  output logic               out_clipped,
  output logic               out_last
);
  import mbeq_pkg::*;

  // The controller walks the bands of one sample; the datapath holds the memories,
  // the shared multiplier, the accumulator and the output register.
  dp_cmd_t    cmd;
  dp_status_t status;

  mbeq_ctrl #(.BANDS(BANDS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // A result waits in the output register while the next transaction is accepted.
  mbeq_dp #(
    .BANDS             (BANDS),
    .CHANNELS          (CHANNELS),
    .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS),
    .COEF_FRAC_BITS    (COEF_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_action),
    .in_channel       (in_channel),
    .in_sample_in     (in_sample_in),
    .in_last_of_block (in_last_of_block),
    .in_band          (in_band),
    .in_coef_index    (in_coef_index),
    .in_coef_value    (in_coef_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel      (out_channel),
    .out_sample_out   (out_sample_out),
    .out_clipped      (out_clipped),
    .out_last         (out_last)
  );

endmodule

### sv/mbeq_checker.sv
`include "multiband_biquad_equalizer_assert.svh"

module mbeq_checker #(
  parameter int CHANNELS = 2
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_action,
  input logic [2:0]         in_channel,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] out_sample_out,
  input logic               out_clipped
);
  import mbeq_pkg::*;

  logic sample_taken;
  logic at_rail;
  logic out_held;

  assign sample_taken = in_valid && in_ready && (in_action == ACT_SAMPLE)
                        && (4'(in_channel) < 4'(CHANNELS));
  assign at_rail  = (out_sample_out == 24'sh7FFFFF) || (out_sample_out == 24'sh800000);
  assign out_held = out_valid && !out_ready;

  // A valid sample starts the band walk, so no further transaction is taken next cycle.
  `MBEQ_ASSERT(a_busy_after_sample, sample_taken |=> !in_ready)
  // A coefficient write completes at once.
  `MBEQ_ASSERT(a_coef_no_stall, in_valid && in_ready && (in_action == ACT_COEF) |=> in_ready)
  // A result only appears at the end of a band walk.
  `MBEQ_ASSERT(a_result_after_work, $rose(out_valid) |-> !$past(in_ready))
  // The clip flag goes with a saturated sample.
  `MBEQ_ASSERT(a_clip_at_rail, out_valid && out_clipped |-> at_rail)
  // A result that is not taken stays.
  `MBEQ_ASSERT_ALWAYS(a_out_hold, rst_n && $past(rst_n) && $past(out_held) |-> out_valid && $stable(out_sample_out))

endmodule

bind multiband_biquad_equalizer mbeq_checker #(.CHANNELS(CHANNELS)) u_mbeq_checker (.*);

### test/multiband_biquad_equalizer_check.sv
module multiband_biquad_equalizer_check
  import mbeq_pkg::*;
#(
  parameter int BANDS    = 10,
  parameter int CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_action,
  input  logic [2:0]         in_channel,
  input  logic signed [23:0] in_sample_in,
  input  logic               in_last_of_block,
  input  logic [3:0]         in_band,
  input  logic [2:0]         in_coef_index,
  input  logic signed [31:0] in_coef_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_channel,
  input  logic signed [23:0] out_sample_out,
  input  logic               out_clipped,
  input  logic               out_last,
  output int                 error_count,
  output int                 results_waiting,
  output int                 results_checked
);

  localparam int COEF_B0 = 0;
  localparam int COEF_B1 = 1;
  localparam int COEF_B2 = 2;
  localparam int COEF_A1 = 3;
  localparam int COEF_A2 = 4;
  localparam int HIST_X1 = 0;
  localparam int HIST_X2 = 1;
  localparam int HIST_Y1 = 2;
  localparam int HIST_Y2 = 3;

  typedef struct {
    logic [2:0]         channel;
    logic signed [23:0] sample;
    logic               clipped;
    logic               last;
  } eq_result_t;

  logic signed [31:0] coefs [BANDS][NUM_COEFS];
  logic signed [31:0] hist [BANDS][CHANNELS][4];
  logic [ENABLE_BITS-1:0] band_mask;
  logic [31:0] preamp;
  eq_result_t pending_results [$];
  int n_errors;
  int n_checked;

  // Runs one sample through the enabled bands and the output gain stage,
  // updating the per-channel history as it goes.
  function automatic eq_result_t equalize(logic [2:0] ch, logic signed [23:0] smp,
                                          logic lst);
    logic signed [71:0] acc;
    logic signed [71:0] rnd;
    logic signed [71:0] gain;
    logic signed [31:0] x;
    logic signed [31:0] y;
    eq_result_t r;
    x = {{7{smp[23]}}, smp, 1'b0};
    for (int b = 0; b < BANDS; b++) begin
      if (band_mask[b]) begin
        acc = coefs[b][COEF_B0] * x
            + coefs[b][COEF_B1] * hist[b][ch][HIST_X1]
            + coefs[b][COEF_B2] * hist[b][ch][HIST_X2]
            - coefs[b][COEF_A1] * hist[b][ch][HIST_Y1]
            - coefs[b][COEF_A2] * hist[b][ch][HIST_Y2];
        rnd = (acc + (72'sd1 <<< 27)) >>> 28;
        if (rnd > 72'sd2147483647) y = 32'sh7fffffff;
        else if (rnd < -72'sd2147483648) y = 32'sh80000000;
        else y = rnd[31:0];
        hist[b][ch][HIST_X2] = hist[b][ch][HIST_X1];
        hist[b][ch][HIST_X1] = x;
        hist[b][ch][HIST_Y2] = hist[b][ch][HIST_Y1];
        hist[b][ch][HIST_Y1] = y;
        x = y;
      end
    end
    gain = {40'd0, preamp};
    acc = x * gain;
    rnd = (acc + (72'sd1 <<< 28)) >>> 29;
    r.clipped = 1'b1;
    if (rnd > 72'sd8388607) r.sample = 24'sh7fffff;
    else if (rnd < -72'sd8388608) r.sample = 24'sh800000;
    else begin
      r.sample = rnd[23:0];
      r.clipped = 1'b0;
    end
    r.channel = ch;
    r.last = lst;
    return r;
  endfunction

  always @(posedge clk) begin
    eq_result_t want;
    if (!rst_n) begin
      foreach (coefs[b, c]) coefs[b][c] = '0;
      foreach (hist[b, c, k]) hist[b][c][k] = '0;
      band_mask = '0;
      preamp = 32'h1000_0000;
      pending_results.delete();
      n_errors = 0;
      n_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: channel %0d sample %0d", out_channel, out_sample_out);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (out_channel !== want.channel) begin
            $error("out_channel: expected %0d, got %0d", want.channel, out_channel);
            n_errors++;
          end
          if (out_sample_out !== want.sample) begin
            $error("out_sample_out: expected %0d, got %0d", want.sample, out_sample_out);
            n_errors++;
          end
          if (out_clipped !== want.clipped) begin
            $error("out_clipped: expected %0d, got %0d", want.clipped, out_clipped);
            n_errors++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_last);
            n_errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_COEF) begin
          if (in_band < BANDS && in_coef_index < NUM_COEFS)
            coefs[in_band][in_coef_index] = in_coef_value;
        end else if (in_channel < CHANNELS) begin
          pending_results.push_back(equalize(in_channel, in_sample_in, in_last_of_block));
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_BAND_ENABLE) band_mask = cfg_wdata[ENABLE_BITS-1:0];
        else preamp = cfg_wdata;
      end
    end
    error_count <= n_errors;
    results_waiting <= pending_results.size();
    results_checked <= n_checked;
  end

endmodule

### test/multiband_biquad_equalizer_test.sv
module multiband_biquad_equalizer_test;
  import mbeq_pkg::*;

  localparam int BANDS = 10;
  localparam int CHANNELS = 2;
  localparam logic [31:0] UNITY_GAIN = 32'h1000_0000;
  // Longest quiet stretch the watchdog tolerates before declaring a hang.
  localparam int WATCHDOG_LIMIT = 20000;
  // Generous bound on the time one transaction can keep the block busy.
  localparam int SETTLE_CYCLES = 120;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_index = 1'b0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_action = 1'b0;
  logic [2:0]         in_channel = '0;
  logic signed [23:0] in_sample_in = '0;
  logic               in_last_of_block = 1'b0;
  logic [3:0]         in_band = '0;
  logic [2:0]         in_coef_index = '0;
  logic signed [31:0] in_coef_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_channel;
  logic signed [23:0] out_sample_out;
  logic               out_clipped;
  logic               out_last;

  int error_count;
  int results_waiting;
  int results_checked;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  // Set while the receiver is forced to hold off for the back-pressure test.
  logic hold_off = 1'b0;
  // Tracks whether in_valid has been raised and not yet lowered.
  bit input_high = 1'b0;
  int idle_cycles = 0;
  int samples_sent = 0;
  int coef_writes_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  multiband_biquad_equalizer #(
    .BANDS(BANDS),
    .CHANNELS(CHANNELS)
  ) dut (.*);

  multiband_biquad_equalizer_check #(
    .BANDS(BANDS),
    .CHANNELS(CHANNELS)
  ) checker_inst (.*);

  // The receiver accepts results at random according to the current stall rate,
  // except during a forced hold-off.
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
  end

  // The watchdog ends the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offers one transaction and waits until the block takes it. Afterwards the
  // sender may go quiet for a random number of cycles.
  task automatic send_item(logic act, logic [2:0] ch, logic signed [23:0] smp, logic lst,
                           logic [3:0] bnd, logic [2:0] ci, logic signed [31:0] val);
    in_action <= act;
    in_channel <= ch;
    in_sample_in <= smp;
    in_last_of_block <= lst;
    in_band <= bnd;
    in_coef_index <= ci;
    in_coef_value <= val;
    in_valid <= 1'b1;
    input_high = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_COEF) coef_writes_sent++;
    else samples_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      input_high = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_sample(logic [2:0] ch, logic signed [23:0] smp, logic lst);
    send_item(ACT_SAMPLE, ch, smp, lst, 4'($urandom), 3'($urandom), 32'($urandom));
  endtask

  task automatic send_coef(logic [3:0] bnd, logic [2:0] ci, logic signed [31:0] val);
    send_item(ACT_COEF, 3'($urandom), 24'($urandom), 1'($urandom), bnd, ci, val);
  endtask

  // Lowers valid, waits for every expected result, then lets the block settle
  // in case the last transactions were ones that give no result.
  task automatic drain();
    if (input_high) begin
      in_valid <= 1'b0;
      input_high = 1'b0;
    end
    @(posedge clk);
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A random transaction. Most coefficient values are mild so that the filters
  // stay in a useful range; some are fully random to reach saturation.
  task automatic send_random();
    logic [3:0] bnd;
    logic [2:0] ci;
    logic signed [31:0] val;
    logic [2:0] ch;
    logic signed [23:0] smp;
    if ($urandom_range(99) < 12) begin
      bnd = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(BANDS - 1));
      ci = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(NUM_COEFS - 1));
      if ($urandom_range(99) < 20) val = $urandom;
      else if (ci == 0) val = UNITY_GAIN + $signed(32'($urandom_range(0, 32'h0400_0000)))
                              - 32'sh0200_0000;
      else val = $signed(32'($urandom_range(0, 32'h0800_0000))) - 32'sh0400_0000;
      send_coef(bnd, ci, val);
    end else begin
      ch = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(CHANNELS - 1));
      case ($urandom_range(9))
        0: smp = 24'sh7fffff;
        1: smp = 24'sh800000;
        default: smp = 24'($urandom);
      endcase
      send_sample(ch, smp, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With the reset settings every band is bypassed at unity gain.
    send_sample(3'd0, 24'sh7fffff, 1'b0);
    send_sample(3'd1, 24'sh800000, 1'b1);
    // An enabled band that has never been loaded gives silence.
    write_reg(CFG_BAND_ENABLE, 32'h1);
    send_sample(3'd0, 24'sd1000, 1'b0);
    // Load band 0 as a mild filter, then try addresses that must be ignored.
    send_coef(4'd0, 3'd0, UNITY_GAIN);
    send_coef(4'd0, 3'd1, 32'sh0100_0000);
    send_coef(4'd0, 3'd3, -32'sh0200_0000);
    send_coef(4'd12, 3'd0, 32'sh7fffffff);
    send_coef(4'd15, 3'd2, 32'sh7fffffff);
    send_coef(4'd0, 3'd5, 32'sh8000_0000);
    send_coef(4'd0, 3'd7, 32'sh7fffffff);
    send_sample(3'd0, 24'sh7fffff, 1'b0);
    send_sample(3'd1, 24'sh800000, 1'b1);
    send_sample(3'd0, 24'sd0, 1'b0);
    // Channels beyond the configured count are dropped without a result.
    send_sample(3'd2, 24'sd5, 1'b1);
    send_sample(3'd7, 24'sh800000, 1'b0);
    // Largest gain forces clipping in both directions.
    write_reg(CFG_PREAMP_GAIN, 32'hffff_ffff);
    send_sample(3'd1, 24'sh7fffff, 1'b0);
    send_sample(3'd0, 24'sh800000, 1'b0);
    write_reg(CFG_PREAMP_GAIN, 32'h0);
    send_sample(3'd1, 24'sh7fffff, 1'b1);
    // All bands on, with the extreme coefficients in the last band.
    write_reg(CFG_BAND_ENABLE, 32'h3ff);
    write_reg(CFG_PREAMP_GAIN, UNITY_GAIN);
    send_coef(4'd9, 3'd0, 32'sh7fffffff);
    send_coef(4'd9, 3'd4, 32'sh8000_0000);
    send_sample(3'd0, 24'sh7fffff, 1'b0);
    send_sample(3'd0, 24'sh800000, 1'b1);

    // Random part, one phase per idling pattern, each with its own settings.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          rx_stall_pct = 0;
          write_reg(CFG_BAND_ENABLE, 32'h3ff);
          write_reg(CFG_PREAMP_GAIN, UNITY_GAIN);
        end
        1: begin
          send_idle_pct = 85;
          rx_stall_pct = 0;
          write_reg(CFG_BAND_ENABLE, 32'h0);
          write_reg(CFG_PREAMP_GAIN, 32'hffff_ffff);
        end
        2: begin
          send_idle_pct = 0;
          rx_stall_pct = 85;
          write_reg(CFG_BAND_ENABLE, $urandom_range(1023));
          write_reg(CFG_PREAMP_GAIN, $urandom_range(0, 32'h2000_0000));
        end
        default: begin
          send_idle_pct = 32;
          rx_stall_pct = 32;
          write_reg(CFG_BAND_ENABLE, $urandom_range(1023));
          write_reg(CFG_PREAMP_GAIN, $urandom);
        end
      endcase
      if (phase == 0) begin
        // Hold the receiver off for a long stretch while items keep coming, so
        // that the block backs up and stalls its input.
        fork
          begin
            @(posedge clk);
            hold_off <= 1'b1;
            repeat (600) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      repeat (410) send_random();
    end

    drain();
    $display("Run covered %0d samples and %0d coefficient writes; %0d results checked.",
             samples_sent, coef_writes_sent, results_checked);
    $display("Idling phases: none, sender 85%%, receiver 85%%, both 32%%, plus one hold-off.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### multiband_biquad_equalizer.f
+incdir+sv
sv/mbeq_pkg.sv
sv/mbeq_ram.sv
sv/mbeq_ctrl.sv
sv/mbeq_dp.sv
sv/multiband_biquad_equalizer.sv
sv/mbeq_checker.sv
test/multiband_biquad_equalizer_check.sv
test/multiband_biquad_equalizer_test.sv
